>>> src/vlas_pkg.sv
`default_nettype none

package vlas_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_GAIN  = 2'd1;

    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 31'd1966080;
    localparam logic [CFG_W-1:0] LIMIT_GAIN_RST  = 31'd655360;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    localparam int TANH_GAIN      = 20;
    localparam int TANH_SPAN      = 8;
    localparam int TANH_SPAN_LOG2 = 3;
    localparam int TAYLOR_TERMS   = 40;
    localparam int Q30            = 30;
    localparam int T_W            = 31;
    localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

    // restoring division, table construction only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

endpackage

`default_nettype wire

>>> src/velocity_limited_accel_smoother.sv
// Throughput: one item per cycle; busy stays low, the 12-stage pipeline never stalls.
// The receiver cannot stall: done and smoothed_accel are valid for exactly one cycle.
// Reset (rst_n low, async): pipeline valid bits clear, speed_limit = 30.0, limit_gain = 10.0.
// The tanh table is a constant built at elaboration; no clearing pass after reset.
`default_nettype none

module velocity_limited_accel_smoother #(
    parameter int TANH_TABLE_DEPTH = 256,
    parameter int FRAC_BITS        = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vlas_pkg::DATA_W-1:0]   desired_accel,
    input  logic signed [vlas_pkg::DATA_W-1:0]   current_speed,
    output logic                                 done,
    output logic signed [vlas_pkg::DATA_W-1:0]   smoothed_accel,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [vlas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [vlas_pkg::DATA_W-1:0]   cfg_data
);

    import vlas_pkg::*;

    localparam int LAT    = 12;
    localparam int AX_W   = FRAC_BITS + TANH_SPAN_LOG2;
    localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int POS_W  = AX_W + IDX_W;
    localparam int X_W    = DATA_W + 5;
    localparam int PROD_W = CFG_W + DATA_W;
    localparam int MAG_W  = PROD_W - FRAC_BITS;
    localparam int IP_W   = T_W + AX_W;
    localparam int SQ_W   = 2 * T_W;
    localparam int MP_W   = DATA_W + T_W;
    localparam logic [X_W-1:0] X_SAT = X_W'(TANH_SPAN) << FRAC_BITS;

    typedef logic [TANH_TABLE_DEPTH:0][T_W-1:0] tanh_tab_t;

    // tanh(i*8/DEPTH) in unsigned Q1.30, i = 0..DEPTH
    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t   tab;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] ex;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] den;
        a    = udiv64(64'(2 * TANH_SPAN) << Q30, 64'(TANH_TABLE_DEPTH));
        term = 64'(ONE_Q30);
        ex   = term;
        p    = term;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = udiv64((term * a) >> Q30, 64'(k));
            ex   = ex + term;
        end
        q = udiv64(64'd1 << (2 * Q30), ex);
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++)
        begin
            if (i > 0)
            begin
                p = (p * q + (64'd1 << (Q30 - 1))) >> Q30;
            end
            den    = 64'(ONE_Q30) + p;
            tab[i] = T_W'(udiv64(((64'(ONE_Q30) - p) << Q30) + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

    logic                    accept;
    logic [CFG_W-1:0]        speed_limit_reg;
    logic [CFG_W-1:0]        limit_gain_reg;
    logic [DATA_W-1:0]       vmax_ext;
    logic [LAT-1:0]          vld_reg;

    // stage 1
    logic signed [DATA_W-1:0] want1_reg;
    logic signed [DATA_W-1:0] spd1_reg;
    logic                     neg1_reg, neg1_next;
    logic                     over1_reg, over1_next;
    logic [DATA_W-1:0]        err1_reg, err1_next;
    // stage 2
    logic signed [DATA_W-1:0] want2_reg;
    logic signed [DATA_W-1:0] spd2_reg;
    logic                     neg2_reg;
    logic                     over2_reg;
    logic [PROD_W-1:0]        prod2_reg, prod2_next;
    // stage 3
    logic [MAG_W-1:0]         dmp_mag;
    logic                     dmp_big;
    logic signed [DATA_W-1:0] dt_hi, dt_lo;
    logic signed [DATA_W-1:0] damped3_reg, damped3_next;
    logic signed [DATA_W-1:0] spd3_reg;
    // stage 4
    logic [DATA_W-1:0]        limit;
    logic [DATA_W:0]          d_diff;
    logic [DATA_W-1:0]        ad4_reg, ad4_next;
    logic                     dneg4_reg;
    logic [DATA_W-1:0]        dmag4_reg, dmag4_next;
    // stage 5
    logic [X_W-1:0]           x_arg;
    logic                     sat5_reg;
    logic [AX_W-1:0]          ax5_reg;
    logic                     dneg5_reg;
    logic [DATA_W-1:0]        dmag5_reg;
    // stage 6
    logic [POS_W-1:0]         pos;
    logic [IDX_W-1:0]         idx6_reg;
    logic [AX_W-1:0]          frac6_reg;
    logic                     sat6_reg, sat6_next;
    logic                     dneg6_reg;
    logic [DATA_W-1:0]        dmag6_reg;
    // stage 7
    logic [IDX_W-1:0]         rd_idx;
    logic [T_W-1:0]           lo7_reg, hi7_reg;
    logic [AX_W-1:0]          frac7_reg;
    logic                     sat7_reg;
    logic                     dneg7_reg;
    logic [DATA_W-1:0]        dmag7_reg;
    // stage 8
    logic                     up8_next;
    logic [T_W-1:0]           diff8;
    logic [IP_W-1:0]          ip8_reg, ip8_next;
    logic [T_W-1:0]           lo8_reg;
    logic                     up8_reg;
    logic                     sat8_reg;
    logic                     dneg8_reg;
    logic [DATA_W-1:0]        dmag8_reg;
    // stage 9
    logic [T_W-1:0]           step9;
    logic [T_W:0]             sum9;
    logic [T_W-1:0]           t9_reg, t9_next;
    logic                     dneg9_reg;
    logic [DATA_W-1:0]        dmag9_reg;
    // stage 10
    logic [SQ_W-1:0]          sq10_reg;
    logic                     dneg10_reg;
    logic [DATA_W-1:0]        dmag10_reg;
    // stage 11
    logic [MP_W-1:0]          mp11_reg, mp11_next;
    logic                     dneg11_reg;
    // stage 12
    logic [MP_W-Q30-1:0]      res_mag;
    logic signed [DATA_W-1:0] res12_reg, res12_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign vmax_ext  = {1'b0, speed_limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RST;
            limit_gain_reg  <= LIMIT_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[CFG_W-1:0];
                REG_LIMIT_GAIN:  limit_gain_reg  <= cfg_data[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    always_comb
    begin
        // stage 1: bound check and speed error
        neg1_next  = current_speed[DATA_W-1];
        over1_next = !neg1_next && (current_speed > $signed(vmax_ext));
        err1_next  = neg1_next ? DATA_W'(-$unsigned(current_speed))
                               : DATA_W'($unsigned(current_speed) - vmax_ext);

        // stage 2: gain product
        prod2_next = PROD_W'(limit_gain_reg) * PROD_W'(err1_reg);

        // stage 3: saturated damping term and clamp
        dmp_mag = prod2_reg[PROD_W-1:FRAC_BITS];
        dmp_big = |dmp_mag[MAG_W-1:DATA_W-1];
        dt_hi   = dmp_big ? DATA_MAX : $signed({1'b0, dmp_mag[DATA_W-2:0]});
        dt_lo   = dmp_big ? DATA_MIN : -$signed({1'b0, dmp_mag[DATA_W-2:0]});
        if (neg2_reg)
        begin
            damped3_next = (want2_reg > dt_hi) ? want2_reg : dt_hi;
        end
        else if (over2_reg)
        begin
            damped3_next = (want2_reg < dt_lo) ? want2_reg : dt_lo;
        end
        else
        begin
            damped3_next = want2_reg;
        end

        // stage 4: distance to the relevant limit
        limit      = damped3_reg[DATA_W-1] ? '0 : vmax_ext;
        d_diff     = {spd3_reg[DATA_W-1], spd3_reg} - {1'b0, limit};
        ad4_next   = d_diff[DATA_W] ? DATA_W'(-d_diff) : d_diff[DATA_W-1:0];
        dmag4_next = damped3_reg[DATA_W-1] ? DATA_W'(-damped3_reg) : DATA_W'(damped3_reg);

        // stage 5: tanh argument
        x_arg = X_W'(ad4_reg) * X_W'(TANH_GAIN);

        // stage 6: table position
        pos       = POS_W'(ax5_reg) * POS_W'(TANH_TABLE_DEPTH);
        sat6_next = sat5_reg || (pos[POS_W-1:AX_W] >= IDX_W'(TANH_TABLE_DEPTH));

        // stage 7: table read
        rd_idx = sat6_reg ? '0 : idx6_reg;

        // stage 8: interpolation product
        up8_next = hi7_reg >= lo7_reg;
        diff8    = up8_next ? (hi7_reg - lo7_reg) : (lo7_reg - hi7_reg);
        ip8_next = IP_W'(diff8) * IP_W'(frac7_reg);

        // stage 9: interpolated tanh
        step9 = ip8_reg[IP_W-1:AX_W];
        sum9  = up8_reg ? ({1'b0, lo8_reg} + {1'b0, step9})
                        : ({1'b0, lo8_reg} - {1'b0, step9});
        t9_next = (sat8_reg || (sum9 > {1'b0, ONE_Q30})) ? ONE_Q30 : sum9[T_W-1:0];

        // stage 11: scale magnitude by tanh^2
        mp11_next = MP_W'(dmag10_reg) * MP_W'(sq10_reg[Q30+T_W-1:Q30]);

        // stage 12: restore sign
        res_mag    = mp11_reg[MP_W-1:Q30];
        res12_next = dneg11_reg ? -$signed(res_mag[DATA_W-1:0])
                                : $signed(res_mag[DATA_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        want1_reg   <= desired_accel;
        spd1_reg    <= current_speed;
        neg1_reg    <= neg1_next;
        over1_reg   <= over1_next;
        err1_reg    <= err1_next;

        want2_reg   <= want1_reg;
        spd2_reg    <= spd1_reg;
        neg2_reg    <= neg1_reg;
        over2_reg   <= over1_reg;
        prod2_reg   <= prod2_next;

        damped3_reg <= damped3_next;
        spd3_reg    <= spd2_reg;

        ad4_reg     <= ad4_next;
        dneg4_reg   <= damped3_reg[DATA_W-1];
        dmag4_reg   <= dmag4_next;

        sat5_reg    <= x_arg >= X_SAT;
        ax5_reg     <= x_arg[AX_W-1:0];
        dneg5_reg   <= dneg4_reg;
        dmag5_reg   <= dmag4_reg;

        idx6_reg    <= pos[POS_W-1:AX_W];
        frac6_reg   <= pos[AX_W-1:0];
        sat6_reg    <= sat6_next;
        dneg6_reg   <= dneg5_reg;
        dmag6_reg   <= dmag5_reg;

        lo7_reg     <= TANH_TAB[rd_idx];
        hi7_reg     <= TANH_TAB[rd_idx + IDX_W'(1)];
        frac7_reg   <= frac6_reg;
        sat7_reg    <= sat6_reg;
        dneg7_reg   <= dneg6_reg;
        dmag7_reg   <= dmag6_reg;

        ip8_reg     <= ip8_next;
        lo8_reg     <= lo7_reg;
        up8_reg     <= up8_next;
        sat8_reg    <= sat7_reg;
        dneg8_reg   <= dneg7_reg;
        dmag8_reg   <= dmag7_reg;

        t9_reg      <= t9_next;
        dneg9_reg   <= dneg8_reg;
        dmag9_reg   <= dmag8_reg;

        sq10_reg    <= SQ_W'(t9_reg) * SQ_W'(t9_reg);
        dneg10_reg  <= dneg9_reg;
        dmag10_reg  <= dmag9_reg;

        mp11_reg    <= mp11_next;
        dneg11_reg  <= dneg10_reg;

        res12_reg   <= res12_next;
    end

    assign done           = vld_reg[LAT-1];
    assign smoothed_accel = res12_reg;

`ifndef SYNTH
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("item accepted without a result LAT cycles later");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching accepted item");

    a_tanh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] |-> (t9_reg <= ONE_Q30))
        else $error("interpolated tanh above one");

    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (smoothed_accel != '0))
            |-> (smoothed_accel[DATA_W-1] == $past(damped3_reg[DATA_W-1], LAT - 3)))
        else $error("result sign differs from damped value sign");
`endif

endmodule

`default_nettype wire
